// ===== sv/bellman_ford_shortest_paths_assert.svh =====
// Assertion macros for the top-level file, which checks its own logic.
`ifndef BELLMAN_FORD_SHORTEST_PATHS_ASSERT_SVH
`define BELLMAN_FORD_SHORTEST_PATHS_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BFSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BFSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bfsp_pkg.sv =====
package bfsp_pkg;

    localparam int VID_W       = 5;
    localparam int VCOUNT_W    = 6;
    localparam int WEIGHT_W    = 16;
    localparam int DIST_W      = 21;
    localparam int EDGE_W      = 2 * VID_W + WEIGHT_W;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 6;

    localparam int MAX_VERTICES_DEF = 32;
    localparam int MAX_EDGES_DEF    = 128;

    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_VERTEX = 1'd1;

    localparam logic [VCOUNT_W-1:0] VERTEX_COUNT_RESET  = 6'd32;
    localparam logic [VID_W-1:0]    SOURCE_VERTEX_RESET = 5'd0;

    localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
    localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

    typedef struct packed {
        logic in_ready;
        logic init;
        logic relax_calc;
        logic relax_wr;
        logic out_sel;
        logic out_load;
        logic done;
    } bfsp_cmd_t;

    typedef struct packed {
        logic in_take;
        logic in_last;
        logic out_taken;
    } bfsp_status_t;

endpackage

// ===== sv/bfsp_if.sv =====
interface bfsp_edge_if;
    import bfsp_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       edge_present;
    logic [VID_W-1:0]           edge_from;
    logic [VID_W-1:0]           edge_to;
    logic signed [WEIGHT_W-1:0] edge_weight;
    logic                       last_edge;

    modport source (
        output valid, edge_present, edge_from, edge_to, edge_weight, last_edge,
        input  ready
    );

    modport sink (
        input  valid, edge_present, edge_from, edge_to, edge_weight, last_edge,
        output ready
    );
endinterface

interface bfsp_result_if;
    import bfsp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [VID_W-1:0]         vertex_index;
    logic signed [DIST_W-1:0] path_distance;
    logic                     reachable;
    logic                     last_result;

    modport source (
        output valid, vertex_index, path_distance, reachable, last_result,
        input  ready
    );

    modport sink (
        input  valid, vertex_index, path_distance, reachable, last_result,
        output ready
    );
endinterface

// ===== sv/bfsp_ram.sv =====
module bfsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== sv/bfsp_ctrl.sv =====
module bfsp_ctrl #(
    parameter int MAX_VERTICES = bfsp_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = bfsp_pkg::MAX_EDGES_DEF,
    localparam int V_W   = $clog2(MAX_VERTICES),
    localparam int CNT_W = $clog2(MAX_VERTICES + 1),
    localparam int ET_W  = $clog2(MAX_EDGES + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bfsp_pkg::bfsp_status_t  status,
    input  logic [CNT_W-1:0]        active_n,
    input  logic [ET_W-1:0]         edge_total,
    output bfsp_pkg::bfsp_cmd_t     cmd,
    output logic [ET_W-1:0]         edge_idx,
    output logic [V_W-1:0]          vert_idx
);
    import bfsp_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_INIT     = 4'd1;
    localparam logic [3:0] ST_EREAD    = 4'd2;
    localparam logic [3:0] ST_DREAD    = 4'd3;
    localparam logic [3:0] ST_CALC     = 4'd4;
    localparam logic [3:0] ST_WRITE    = 4'd5;
    localparam logic [3:0] ST_OUT_RD   = 4'd6;
    localparam logic [3:0] ST_OUT_LD   = 4'd7;
    localparam logic [3:0] ST_OUT_WAIT = 4'd8;

    logic [3:0]      state_reg, state_next;
    logic [ET_W-1:0] edge_reg, edge_next;
    logic [V_W-1:0]  pass_reg, pass_next;
    logic [V_W-1:0]  vert_reg, vert_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            edge_reg  <= '0;
            pass_reg  <= '0;
            vert_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            edge_reg  <= edge_next;
            pass_reg  <= pass_next;
            vert_reg  <= vert_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        edge_next  = edge_reg;
        pass_next  = pass_reg;
        vert_next  = vert_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (status.in_take && status.in_last)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                cmd.init  = 1'b1;
                edge_next = '0;
                pass_next = '0;
                vert_next = '0;
                if (active_n > CNT_W'(1) && edge_total != '0)
                begin
                    state_next = ST_EREAD;
                end
                else
                begin
                    state_next = ST_OUT_RD;
                end
            end
            ST_EREAD:
            begin
                state_next = ST_DREAD;
            end
            ST_DREAD:
            begin
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                cmd.relax_calc = 1'b1;
                state_next     = ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.relax_wr = 1'b1;
                if (edge_reg + ET_W'(1) < edge_total)
                begin
                    edge_next  = edge_reg + ET_W'(1);
                    state_next = ST_EREAD;
                end
                else
                begin
                    edge_next = '0;
                    // A new pass starts while fewer than n-1 passes are done.
                    if (CNT_W'(pass_reg) + CNT_W'(2) < active_n)
                    begin
                        pass_next  = pass_reg + V_W'(1);
                        state_next = ST_EREAD;
                    end
                    else
                    begin
                        state_next = ST_OUT_RD;
                    end
                end
            end
            ST_OUT_RD:
            begin
                cmd.out_sel = 1'b1;
                state_next  = ST_OUT_LD;
            end
            ST_OUT_LD:
            begin
                cmd.out_sel  = 1'b1;
                cmd.out_load = 1'b1;
                state_next   = ST_OUT_WAIT;
            end
            ST_OUT_WAIT:
            begin
                if (status.out_taken)
                begin
                    if (CNT_W'(vert_reg) + CNT_W'(1) == active_n)
                    begin
                        cmd.done   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        vert_next  = vert_reg + V_W'(1);
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign edge_idx = edge_reg;
    assign vert_idx = vert_reg;
endmodule

// ===== sv/bfsp_datapath.sv =====
module bfsp_datapath #(
    parameter int MAX_VERTICES = bfsp_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = bfsp_pkg::MAX_EDGES_DEF,
    localparam int V_W   = $clog2(MAX_VERTICES),
    localparam int CNT_W = $clog2(MAX_VERTICES + 1),
    localparam int EA_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
    localparam int ET_W  = $clog2(MAX_EDGES + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    bfsp_edge_if.sink                           edges,
    bfsp_result_if.source                       results,
    input  logic                                cfg_we,
    input  logic [bfsp_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [bfsp_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  bfsp_pkg::bfsp_cmd_t                 cmd,
    input  logic [ET_W-1:0]                     edge_idx,
    input  logic [V_W-1:0]                      vert_idx,
    output bfsp_pkg::bfsp_status_t              status,
    output logic [CNT_W-1:0]                    active_n,
    output logic [ET_W-1:0]                     edge_total
);
    import bfsp_pkg::*;

    logic [VCOUNT_W-1:0]        vertex_count_reg;
    logic [VID_W-1:0]           source_vertex_reg;
    logic [ET_W-1:0]            edge_total_reg;
    logic [MAX_VERTICES-1:0]    reached_reg;

    logic                       in_take;
    logic                       edge_store;
    logic [EDGE_W-1:0]          edge_rdata;
    logic [VID_W-1:0]           e_from;
    logic [VID_W-1:0]           e_to;
    logic signed [WEIGHT_W-1:0] e_weight;
    logic [V_W-1:0]             from_idx;
    logic [V_W-1:0]             to_idx;
    logic                       from_ok;
    logic                       to_ok;
    logic                       src_ok;

    logic [V_W-1:0]             dist_raddr_a;
    logic                       dist_we;
    logic [V_W-1:0]             dist_waddr;
    logic [DIST_W-1:0]          dist_wdata;
    logic signed [DIST_W-1:0]   dist_a;
    logic signed [DIST_W-1:0]   dist_b;

    logic signed [DIST_W:0]     sum;
    logic signed [DIST_W-1:0]   cand_next;
    logic signed [DIST_W-1:0]   cand_reg;
    logic                       ok_reg;
    logic                       relax_upd;

    logic                       out_valid_reg;
    logic [VID_W-1:0]           out_index_reg;
    logic signed [DIST_W-1:0]   out_dist_reg;
    logic                       out_reach_reg;
    logic                       out_last_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg  <= VERTEX_COUNT_RESET;
            source_vertex_reg <= SOURCE_VERTEX_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_VERTEX_COUNT:  vertex_count_reg  <= cfg_data;
                REG_SOURCE_VERTEX: source_vertex_reg <= cfg_data[VID_W-1:0];
            endcase
        end
    end

    // A vertex count of zero means one vertex; counts above the store saturate.
    always_comb
    begin
        if (vertex_count_reg == '0)
        begin
            active_n = CNT_W'(1);
        end
        else if (int'(vertex_count_reg) > MAX_VERTICES)
        begin
            active_n = CNT_W'(MAX_VERTICES);
        end
        else
        begin
            active_n = CNT_W'(vertex_count_reg);
        end
    end

    // Edge loading.
    assign edges.ready = cmd.in_ready;
    assign in_take     = edges.valid & cmd.in_ready;
    assign edge_store  = in_take & edges.edge_present
                       & (edge_total_reg < ET_W'(MAX_EDGES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_total_reg <= '0;
        end
        else if (cmd.done)
        begin
            edge_total_reg <= '0;
        end
        else if (edge_store)
        begin
            edge_total_reg <= edge_total_reg + ET_W'(1);
        end
    end

    assign edge_total = edge_total_reg;

    bfsp_ram #(
        .WIDTH (EDGE_W),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_store),
        .waddr (edge_total_reg[EA_W-1:0]),
        .wdata ({edges.edge_from, edges.edge_to, edges.edge_weight}),
        .raddr (edge_idx[EA_W-1:0]),
        .rdata (edge_rdata)
    );

    assign e_from   = edge_rdata[EDGE_W-1 -: VID_W];
    assign e_to     = edge_rdata[WEIGHT_W +: VID_W];
    assign e_weight = edge_rdata[WEIGHT_W-1:0];
    assign from_idx = V_W'(e_from);
    assign to_idx   = V_W'(e_to);
    assign from_ok  = int'(e_from) < int'(active_n);
    assign to_ok    = int'(e_to) < int'(active_n);
    assign src_ok   = int'(source_vertex_reg) < int'(active_n);

    // Two copies of the distance table, written together, give two read ports.
    assign dist_raddr_a = cmd.out_sel ? vert_idx : from_idx;
    assign dist_we      = cmd.init | (cmd.relax_wr & relax_upd);
    assign dist_waddr   = cmd.init ? V_W'(source_vertex_reg) : to_idx;
    assign dist_wdata   = cmd.init ? '0 : cand_reg;

    bfsp_ram #(
        .WIDTH (DIST_W),
        .DEPTH (MAX_VERTICES)
    ) u_dist_ram_a (
        .clk   (clk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (dist_wdata),
        .raddr (dist_raddr_a),
        .rdata (dist_a)
    );

    bfsp_ram #(
        .WIDTH (DIST_W),
        .DEPTH (MAX_VERTICES)
    ) u_dist_ram_b (
        .clk   (clk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (dist_wdata),
        .raddr (to_idx),
        .rdata (dist_b)
    );

    // Reached flags double as valid bits for the distance table.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reached_reg <= '0;
        end
        else if (cmd.init)
        begin
            reached_reg <= '0;
            if (src_ok)
            begin
                reached_reg[V_W'(source_vertex_reg)] <= 1'b1;
            end
        end
        else if (cmd.relax_wr && relax_upd)
        begin
            reached_reg[to_idx] <= 1'b1;
        end
    end

    // Candidate distance, saturated to the distance range.
    assign sum = {dist_a[DIST_W-1], dist_a}
               + {{(DIST_W + 1 - WEIGHT_W){e_weight[WEIGHT_W-1]}}, e_weight};

    always_comb
    begin
        if (sum[DIST_W] != sum[DIST_W-1])
        begin
            cand_next = sum[DIST_W] ? DIST_MIN : DIST_MAX;
        end
        else
        begin
            cand_next = sum[DIST_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg <= 1'b0;
        end
        else if (cmd.relax_calc)
        begin
            ok_reg <= from_ok & to_ok & reached_reg[from_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.relax_calc)
        begin
            cand_reg <= cand_next;
        end
    end

    assign relax_upd = ok_reg & (!reached_reg[to_idx] || (cand_reg < dist_b));

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_index_reg <= VID_W'(vert_idx);
            out_reach_reg <= reached_reg[vert_idx];
            out_dist_reg  <= reached_reg[vert_idx] ? dist_a : '0;
            out_last_reg  <= (CNT_W'(vert_idx) + CNT_W'(1)) == active_n;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.vertex_index  = out_index_reg;
    assign results.path_distance = out_dist_reg;
    assign results.reachable     = out_reach_reg;
    assign results.last_result   = out_last_reg;

    assign status.in_take   = in_take;
    assign status.in_last   = edges.last_edge;
    assign status.out_taken = out_valid_reg & results.ready;
endmodule

// ===== sv/bellman_ford_shortest_paths.sv =====
// Single-source shortest paths over a loaded edge list.
// The edges channel takes one word per cycle while the block is idle; each word
// with edge_present set is stored in load order (words past MAX_EDGES are dropped).
// A word with last_edge set starts the solve and the channel stalls until every
// result has been taken. The solve runs n - 1 passes over the E stored edges for
// n active vertices (none if n is 1 or E is 0): each edge relaxation walks four
// steps through the edge memory read, the distance memory read, the saturating
// add and the compare-and-write. The results channel then gives one word per
// vertex, vertex 0 first, with last_result on vertex n - 1. Each result is read
// from the distance table into an output register and held there until taken;
// the next vertex is not read before that. After the last result the edge list
// is emptied and the block returns to idle.
// Configuration writes are taken at any cycle and must only happen while idle.
// Reset returns the block to idle with an empty edge list, vertex_count 32 and
// source_vertex 0; no memory clearing pass is needed.
module bellman_ford_shortest_paths #(
    parameter int MAX_VERTICES = bfsp_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = bfsp_pkg::MAX_EDGES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    bfsp_edge_if.sink                       edges,
    bfsp_result_if.source                   results,
    input  logic                            cfg_we,
    input  logic [bfsp_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [bfsp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bfsp_pkg::*;

    localparam int V_W   = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int ET_W  = $clog2(MAX_EDGES + 1);

    bfsp_cmd_t        cmd;
    bfsp_status_t     status;
    logic [CNT_W-1:0] active_n;
    logic [ET_W-1:0]  edge_total;
    logic [ET_W-1:0]  edge_idx;
    logic [V_W-1:0]   vert_idx;

    bfsp_ctrl #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .status     (status),
        .active_n   (active_n),
        .edge_total (edge_total),
        .cmd        (cmd),
        .edge_idx   (edge_idx),
        .vert_idx   (vert_idx)
    );

    bfsp_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .edges      (edges),
        .results    (results),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .edge_idx   (edge_idx),
        .vert_idx   (vert_idx),
        .status     (status),
        .active_n   (active_n),
        .edge_total (edge_total)
    );

`include "bellman_ford_shortest_paths_assert.svh"

    `BFSP_ASSERT_NOW(a_no_load_while_reporting, edges.ready, !results.valid,
        "input open while a result is pending")
    `BFSP_ASSERT_NEXT(a_last_word_closes_input,
        edges.valid && edges.ready && edges.last_edge, !edges.ready,
        "input still open after the last edge")
    `BFSP_ASSERT_NEXT(a_last_result_reopens,
        results.valid && results.ready && results.last_result,
        edges.ready && edge_total == '0, "not idle after the last result")
    `BFSP_ASSERT_NEXT(a_result_held, results.valid && !results.ready, results.valid,
        "result word dropped before it was taken")
endmodule
